// File: rtl/tlbl_pkg.sv
// ----------------------------------------------------------------------------
// tlbl_pkg
// Shared constants and controller/datapath handshake types for the
// fully associative translation buffer with least-frequently-used replacement.
// ----------------------------------------------------------------------------
package tlbl_pkg;

    // default geometry
    localparam int ENTRIES_DEF     = 16;
    localparam int OFFSET_BITS_DEF = 12;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF  = 16;

    // fixed result field widths
    localparam int PAGE_INDEX_W  = 20;
    localparam int PAGE_OFFSET_W = 12;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } tlbl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;    // take the input transaction and do the lookup
        logic scan_step;  // examine one entry of the victim search
        logic commit;     // update the entry and load the result register
    } tlbl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic lookup_hit;   // presented address matches a valid entry
        logic lookup_free;  // an invalid entry exists
        logic scan_last;    // victim search is at the last entry
        logic out_free;     // result register can take a new result
    } tlbl_sts_t;

endpackage

// File: rtl/tlb_lookup_lfu_replace.sv
// Sequence: accept and lookup, then commit of the entry update and the result register.
// A miss with every entry valid adds a victim scan between them (one entry
// per cycle through the count read port). Commit waits while the result is held.
// A new transaction is accepted only after the last one has committed.
// Reset: synchronous, clears all valid bits, the sequencer and the result valid.
// ----------------------------------------------------------------------------
// tlb_lookup_lfu_replace
// Fully associative translation buffer keyed on the whole virtual address,
// with saturating use counts and least-frequently-used replacement.
// ----------------------------------------------------------------------------
module tlb_lookup_lfu_replace #(
    parameter int ENTRIES     = tlbl_pkg::ENTRIES_DEF,
    parameter int OFFSET_BITS = tlbl_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = tlbl_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS  = tlbl_pkg::COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ADDR_BITS-1:0]                s_virtual_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [tlbl_pkg::PAGE_INDEX_W-1:0]   m_page_index,
    output logic [tlbl_pkg::PAGE_OFFSET_W-1:0]  m_page_offset,
    output logic                                m_evicted
);
    import tlbl_pkg::*;

    tlbl_cmd_t cmd;
    tlbl_sts_t sts;

    // sequencer
    tlbl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage, compare and victim search
    tlbl_dpath #(
        .ENTRIES     (ENTRIES),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_virtual_address (s_virtual_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_page_index      (m_page_index),
        .m_page_offset     (m_page_offset),
        .m_evicted         (m_evicted)
    );

endmodule

// File: rtl/tlbl_ctrl.sv
// ----------------------------------------------------------------------------
// tlbl_ctrl
// Sequencer for the translation buffer: lookup on accept, optional victim
// scan over all entries, then commit of the entry update and the result.
// ----------------------------------------------------------------------------
module tlbl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlbl_pkg::tlbl_sts_t sts,
    output tlbl_pkg::tlbl_cmd_t cmd
);
    import tlbl_pkg::*;

    tlbl_state_t state_reg;
    tlbl_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.capture   = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (sts.lookup_hit || sts.lookup_free) begin
                        state_next = ST_COMMIT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/tlbl_dpath.sv
// ----------------------------------------------------------------------------
// tlbl_dpath
// Entry storage, parallel address compare, sequential least-count victim
// search, entry update and the result register.
// ----------------------------------------------------------------------------
module tlbl_dpath #(
    parameter int ENTRIES     = tlbl_pkg::ENTRIES_DEF,
    parameter int OFFSET_BITS = tlbl_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = tlbl_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS  = tlbl_pkg::COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tlbl_pkg::tlbl_cmd_t                 cmd,
    output tlbl_pkg::tlbl_sts_t                 sts,
    input  logic [ADDR_BITS-1:0]                s_virtual_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [tlbl_pkg::PAGE_INDEX_W-1:0]   m_page_index,
    output logic [tlbl_pkg::PAGE_OFFSET_W-1:0]  m_page_offset,
    output logic                                m_evicted
);
    import tlbl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    // entry storage
    logic [ENTRIES-1:0]    valid_reg;
    logic [ADDR_BITS-1:0]  entry_addr_reg  [ENTRIES];
    logic [COUNT_BITS-1:0] entry_count_reg [ENTRIES];

    // transaction context
    logic [ADDR_BITS-1:0]  addr_reg;
    logic                  hit_reg;
    logic                  evict_reg;
    logic [IDX_W-1:0]      sel_idx_reg;
    logic [IDX_W-1:0]      sel_idx_next;
    logic [IDX_W-1:0]      wr_idx_reg;
    logic [IDX_W-1:0]      wr_idx_next;
    logic [COUNT_BITS-1:0] best_reg;
    logic [COUNT_BITS-1:0] best_next;

    // result register
    logic                     out_valid_reg;
    logic                     out_hit_reg;
    logic [PAGE_INDEX_W-1:0]  out_page_reg;
    logic [PAGE_OFFSET_W-1:0] out_offset_reg;
    logic                     out_evict_reg;

    logic [ENTRIES-1:0]    match_vec;
    logic [IDX_W-1:0]      match_idx;
    logic [IDX_W-1:0]      free_idx;
    logic                  any_free;
    logic                  any_match;
    logic [COUNT_BITS-1:0] count_rd;

    logic [ADDR_BITS+PAGE_INDEX_W-1:0]  page_ext;
    logic [ADDR_BITS-1:0]               off_masked;
    logic [ADDR_BITS+PAGE_OFFSET_W-1:0] off_ext;

    // parallel compare and lowest free entry
    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        any_free  = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = valid_reg[i] && (entry_addr_reg[i] == s_virtual_address);
            if (match_vec[i]) begin
                match_idx = match_idx | IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
                any_free = 1'b1;
            end
        end
    end

    assign any_match = |match_vec;
    assign count_rd  = entry_count_reg[sel_idx_reg];

    // status to controller
    assign sts.lookup_hit  = any_match;
    assign sts.lookup_free = any_free;
    assign sts.scan_last   = (sel_idx_reg == IDX_W'(ENTRIES - 1));
    assign sts.out_free    = !out_valid_reg || m_ready;

    // lookup capture and victim search
    always_comb begin
        sel_idx_next = sel_idx_reg;
        wr_idx_next  = wr_idx_reg;
        best_next    = best_reg;
        if (cmd.capture) begin
            sel_idx_next = any_match ? match_idx : '0;
            wr_idx_next  = any_match ? match_idx : free_idx;
        end else if (cmd.scan_step) begin
            // strict less keeps the lowest index on ties
            if (sel_idx_reg == '0 || count_rd < best_reg) begin
                best_next   = count_rd;
                wr_idx_next = sel_idx_reg;
            end
            if (!sts.scan_last) begin
                sel_idx_next = sel_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        sel_idx_reg <= sel_idx_next;
        wr_idx_reg  <= wr_idx_next;
        best_reg    <= best_next;
        if (cmd.capture) begin
            addr_reg  <= s_virtual_address;
            hit_reg   <= any_match;
            evict_reg <= !any_match && !any_free;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.commit && !hit_reg) begin
            valid_reg[wr_idx_reg] <= 1'b1;
        end
    end

    // entry update: saturating count on hit, refill on miss
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (hit_reg) begin
                if (count_rd != '1) begin
                    entry_count_reg[wr_idx_reg] <= count_rd + COUNT_BITS'(1);
                end
            end else begin
                entry_addr_reg[wr_idx_reg]  <= addr_reg;
                entry_count_reg[wr_idx_reg] <= COUNT_BITS'(1);
            end
        end
    end

    // page split of the captured address
    assign page_ext   = {{PAGE_INDEX_W{1'b0}}, addr_reg} >> OFFSET_BITS;
    assign off_masked = addr_reg & ~({ADDR_BITS{1'b1}} << OFFSET_BITS);
    assign off_ext    = {{PAGE_OFFSET_W{1'b0}}, off_masked};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg    <= hit_reg;
            out_page_reg   <= page_ext[PAGE_INDEX_W-1:0];
            out_offset_reg <= off_ext[PAGE_OFFSET_W-1:0];
            out_evict_reg  <= evict_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_hit         = out_hit_reg;
    assign m_page_index  = out_page_reg;
    assign m_page_offset = out_offset_reg;
    assign m_evicted     = out_evict_reg;

endmodule

// File: tb/tlb_lookup_lfu_replace_tb.sv
// ----------------------------------------------------------------------------
// tlb_lookup_lfu_replace_tb
// Self-checking bench for the fully associative translation buffer. A local
// model of the entries, use counts and replacement choice predicts every
// result. Directed tests cover corner addresses, free-entry fills, tie-broken
// replacement and retention of a heavily used entry. Back-pressure, sender
// pauses and random traffic over a small address pool follow.
// ----------------------------------------------------------------------------
module tlb_lookup_lfu_replace_tb;

    localparam int ENTRIES     = tlbl_pkg::ENTRIES_DEF;
    localparam int OFFSET_BITS = tlbl_pkg::OFFSET_BITS_DEF;
    localparam int ADDR_BITS   = tlbl_pkg::ADDR_BITS_DEF;
    localparam int COUNT_BITS  = tlbl_pkg::COUNT_BITS_DEF;
    localparam int PAGE_W      = tlbl_pkg::PAGE_INDEX_W;
    localparam int OFFSET_W    = tlbl_pkg::PAGE_OFFSET_W;

    localparam int RANDOM_ITEMS    = 1350;
    localparam int POOL_SIZE       = 20;
    localparam int HOT_HITS        = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 2 * (ENTRIES + 2) + 4;
    localparam int MAX_REPORTS     = 10;

    localparam logic [ADDR_BITS-1:0] CORNER_ADDRS [ENTRIES] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0FFF, 32'hFFFF_F000,
        32'h0000_1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
        32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
        32'h0000_0FFE, 32'hFEDC_BA98, 32'h0F0F_0F0F, 32'hF0F0_F0F0
    };

    typedef struct packed {
        logic                hit;
        logic [PAGE_W-1:0]   page_index;
        logic [OFFSET_W-1:0] page_offset;
        logic                evicted;
    } xlate_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ADDR_BITS-1:0] s_virtual_address = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_hit;
    logic [PAGE_W-1:0]    m_page_index;
    logic [OFFSET_W-1:0]  m_page_offset;
    logic                 m_evicted;

    // model of the buffer contents
    logic                  tlb_valid [ENTRIES];
    logic [ADDR_BITS-1:0]  tlb_addr  [ENTRIES];
    logic [COUNT_BITS-1:0] tlb_count [ENTRIES];

    xlate_t               expected_xlate [$];
    logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];
    int                   mismatch_count = 0;
    int                   idle_cycles = 0;
    bit                   tx_gaps_on = 1'b0;
    bit                   rx_gaps_on = 1'b0;
    bit                   hold_off_req = 1'b0;

    tlb_lookup_lfu_replace u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_virtual_address (s_virtual_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_page_index      (m_page_index),
        .m_page_offset     (m_page_offset),
        .m_evicted         (m_evicted)
    );

    always #5 aclk = ~aclk;

    // lookup, then hit count bump or fill / least-used replacement
    function automatic xlate_t translate_address(input logic [ADDR_BITS-1:0] va);
        int                    i;
        int                    match;
        int                    free_slot;
        int                    victim;
        int                    slot;
        logic [COUNT_BITS-1:0] least;
        xlate_t                r;
        match = -1;
        free_slot = -1;
        victim = -1;
        least = '0;
        r = '0;
        for (i = 0; i < ENTRIES; i++) begin
            if (tlb_valid[i]) begin
                if (match < 0 && tlb_addr[i] == va)
                    match = i;
                if (victim < 0 || tlb_count[i] < least) begin
                    least = tlb_count[i];
                    victim = i;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (match >= 0) begin
            r.hit = 1'b1;
            if (tlb_count[match] != '1)
                tlb_count[match] = tlb_count[match] + COUNT_BITS'(1);
        end else begin
            if (free_slot >= 0) begin
                slot = free_slot;
            end else begin
                slot = (victim >= 0) ? victim : 0;
                r.evicted = 1'b1;
            end
            tlb_valid[slot] = 1'b1;
            tlb_addr[slot]  = va;
            tlb_count[slot] = COUNT_BITS'(1);
        end
        r.page_index  = PAGE_W'(va >> OFFSET_BITS);
        r.page_offset = OFFSET_W'(va);
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(0, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one address and record its prediction once accepted
    task automatic send_address(input logic [ADDR_BITS-1:0] va);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_virtual_address <= va;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_xlate.push_back(translate_address(va));
    endtask

    // drop valid after the last accepted transaction
    task automatic sender_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        while (expected_xlate.size() != 0) @(posedge aclk);
    endtask

    task automatic flag_mismatch(input string what, input xlate_t want, input xlate_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch (%s): expected hit=%0d page=%05h off=%03h evict=%0d",
                     what, want.hit, want.page_index, want.page_offset, want.evicted);
            $display("    got hit=%0d page=%05h off=%03h evict=%0d",
                     got.hit, got.page_index, got.page_offset, got.evicted);
        end
    endtask

    // fill every entry from empty, then hit the two extreme addresses
    task automatic test_fill_free_entries();
        int n;
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        for (n = 0; n < ENTRIES; n++)
            send_address(CORNER_ADDRS[n]);
        send_address(CORNER_ADDRS[0]);
        send_address(CORNER_ADDRS[1]);
    endtask

    // full buffer: least count replaced, lowest index on ties
    task automatic test_lfu_eviction();
        send_address(32'hDEAD_BEEF);
        send_address(32'hCAFE_F00D);
        send_address(CORNER_ADDRS[2]);
        send_address(32'hDEAD_BEEF);
    endtask

    // build up one heavily used entry, then try to push it out
    task automatic test_hot_entry_retention();
        logic [ADDR_BITS-1:0] hot;
        int                   n;
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hot = $urandom;
        for (n = 0; n < HOT_HITS; n++)
            send_address(hot);
        for (n = 0; n < ENTRIES; n++)
            send_address($urandom);
        send_address(hot);
    endtask

    // receiver stalls long while the sender keeps offering
    task automatic test_output_backpressure();
        int n;
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b1;
        for (n = 0; n < POOL_SIZE; n++)
            addr_pool[n] = $urandom;
        hold_off_req = 1'b1;
        for (n = 0; n < 12; n++)
            send_address(addr_pool[$urandom_range(0, POOL_SIZE - 1)]);
    endtask

    // sender pauses midway until every result so far has arrived, then goes on
    task automatic test_sender_pause();
        int n;
        tx_gaps_on = 1'b1;
        for (n = 0; n < 6; n++)
            send_address(addr_pool[$urandom_range(0, POOL_SIZE - 1)]);
        sender_idle();
        wait_results_drained();
        for (n = 0; n < 6; n++)
            send_address(addr_pool[$urandom_range(0, POOL_SIZE - 1)]);
    endtask

    // pool-heavy traffic for hits and replacements, plus stray addresses
    task automatic test_random_traffic();
        int                   k;
        int                   n;
        int                   sel;
        int                   pick;
        logic [ADDR_BITS-1:0] va;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 150 == 0)
                for (n = 0; n < 5; n++)
                    addr_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
            if (k % 200 == 0) begin
                tx_gaps_on = ((k / 200) % 3) != 2;
                rx_gaps_on = ((k / 200) % 3) != 2;
            end
            sel  = $urandom_range(0, 99);
            pick = $urandom_range(0, POOL_SIZE - 1);
            if (sel < 70)
                va = addr_pool[pick];
            else if (sel < 85)
                va = {addr_pool[pick][ADDR_BITS-1:OFFSET_BITS], OFFSET_BITS'($urandom)};
            else
                va = $urandom;
            send_address(va);
        end
    endtask

    // receiver: random stalls and the long requested hold-off
    initial begin : receiver
        int n;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge aclk);
            end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // compare each result transaction against the oldest prediction
    always @(posedge aclk) begin : result_check
        xlate_t got;
        xlate_t want;
        string  bad;
        if (aresetn && m_valid && m_ready) begin
            got = '{hit: m_hit, page_index: m_page_index,
                    page_offset: m_page_offset, evicted: m_evicted};
            if (expected_xlate.size() == 0) begin
                flag_mismatch("no result expected", '0, got);
            end else begin
                want = expected_xlate.pop_front();
                bad = "";
                if (got.hit !== want.hit) bad = {bad, " hit"};
                if (got.page_index !== want.page_index) bad = {bad, " page_index"};
                if (got.page_offset !== want.page_offset) bad = {bad, " page_offset"};
                if (got.evicted !== want.evicted) bad = {bad, " evicted"};
                if (bad != "")
                    flag_mismatch({"field", bad}, want, got);
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // reset, test sequence and verdict
    initial begin
        int n;
        for (n = 0; n < ENTRIES; n++) begin
            tlb_valid[n] = 1'b0;
            tlb_addr[n]  = '0;
            tlb_count[n] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_free_entries();
        test_lfu_eviction();
        test_hot_entry_retention();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();

        sender_idle();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_xlate.size() != 0)
            $display("%0d results never arrived", expected_xlate.size());
        if (mismatch_count == 0 && expected_xlate.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
